>>> hw/rtl/lps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

    // Action codes carried in the input transaction.
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_ON     = 3'd1;
    localparam logic [2:0] ACT_OFF    = 3'd2;
    localparam logic [2:0] ACT_TOGGLE = 3'd3;
    localparam logic [2:0] ACT_BLINK  = 3'd4;
    localparam logic [2:0] ACT_PLAY   = 3'd5;
    localparam logic [2:0] ACT_STOP   = 3'd6;
    localparam logic [2:0] ACT_WRITE  = 3'd7;

    localparam int FIELD_TIME_W = 32;

    typedef struct packed {
        logic [2:0]              action;
        logic [3:0]              entry_index;
        logic [FIELD_TIME_W-1:0] time_a;
        logic [FIELD_TIME_W-1:0] time_b;
        logic [7:0]              pattern_length;
        logic [7:0]              repeat_limit;
    } t_in_item;

    typedef struct packed {
        logic led_on;
        logic pin_level;
        logic playing;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/led_pattern_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// LED pattern sequencer.
// Input channel (i_in_valid, o_in_ready, i_in_item) carries one action per
// transaction: a one millisecond tick, a direct level change, a blink or table
// playback start, a stop, or a write into the interval table.
// Output channel (o_out_valid, i_out_ready, o_out_item) returns exactly one
// result per input transaction: the logical LED level, the pin level and
// whether playback is running.
// Config channel (i_cfg_valid, o_cfg_ready, i_cfg_data) sets the pin inversion;
// always ready; the user must write it while idle (the block does not check).
// Each result is registered into the result queue when its input is accepted.
// One transaction is accepted per cycle while the queue is not full; the state
// update and registered table read for the next position complete in that cycle.
// A two-entry result queue lets the block keep taking transactions while one
// result waits; o_in_ready drops only when both entries are held by a stalled
// receiver. Synchronous reset clears the LED, playback state, counters and the
// queue; table contents stay undefined until written.

module led_pattern_sequencer_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  lps_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output lps_pkg::t_out_item  o_out_item,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_data
);

    logic               accept;
    logic               not_full;
    lps_pkg::t_out_item result;

    assign o_in_ready  = not_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && not_full;

    lps_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    lps_out_q u_out_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (result),
        .o_not_full (not_full),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_item)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lps_core.sv
`timescale 1ns / 1ps
`default_nettype none

module lps_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  lps_pkg::t_in_item   i_item,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_data,
    output lps_pkg::t_out_item  o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = AW + 1;
    localparam logic [8:0] DEPTH_9 = 9'(TABLE_DEPTH);

    logic [TIME_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [TIME_WIDTH-1:0] r_rd_data;

    logic                  r_invert;
    logic                  r_led,     n_led;
    logic                  r_running, n_running;
    logic                  r_blink,   n_blink;
    logic [TIME_WIDTH-1:0] r_bon,     n_bon;
    logic [TIME_WIDTH-1:0] r_boff,    n_boff;
    logic [AW-1:0]         r_step,    n_step;
    logic [LW-1:0]         r_len,     n_len;
    logic [7:0]            r_rep,     n_rep;
    logic [7:0]            r_passes,  n_passes;
    logic [TIME_WIDTH-1:0] r_el,      n_el;

    logic [TIME_WIDTH-1:0] ta_t;
    logic [TIME_WIDTH-1:0] tb_t;
    logic [TIME_WIDTH-1:0] cur_int;
    logic [TIME_WIDTH-1:0] el_inc;
    logic [LW-1:0]         step_inc;
    logic [7:0]            pass_inc;
    logic [8:0]            len_sat;
    logic [8:0]            idx_9;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;

    assign ta_t    = i_item.time_a[TIME_WIDTH-1:0];
    assign tb_t    = i_item.time_b[TIME_WIDTH-1:0];
    assign idx_9   = {5'd0, i_item.entry_index};
    assign wr_addr = idx_9[AW-1:0];
    assign wr_en   = i_accept && (i_item.action == lps_pkg::ACT_WRITE) && (idx_9 < DEPTH_9);

    // The registered read always holds the interval of the current table position.
    assign cur_int = r_blink ? (r_step[0] ? r_boff : r_bon) : r_rd_data;
    assign el_inc  = (r_el != {TIME_WIDTH{1'b1}}) ? r_el + 1'b1 : r_el;
    assign step_inc = {1'b0, r_step} + 1'b1;
    assign len_sat = ({1'b0, i_item.pattern_length} > DEPTH_9) ?
                     DEPTH_9 : {1'b0, i_item.pattern_length};

    always_comb begin
        n_led     = r_led;
        n_running = r_running;
        n_blink   = r_blink;
        n_bon     = r_bon;
        n_boff    = r_boff;
        n_step    = r_step;
        n_len     = r_len;
        n_rep     = r_rep;
        n_passes  = r_passes;
        n_el      = r_el;
        pass_inc  = r_passes;
        if (i_accept) begin
            unique case (i_item.action)
                lps_pkg::ACT_TICK: begin
                    if (r_running) begin
                        if (el_inc > cur_int) begin
                            n_led = ~r_led;
                            n_el  = '0;
                            if (step_inc >= r_len) begin
                                n_step   = '0;
                                pass_inc = r_passes + 8'd1;
                            end else begin
                                n_step = step_inc[AW-1:0];
                            end
                            n_passes = pass_inc;
                            if ((r_rep != 8'd0) && (pass_inc == r_rep)) begin
                                n_running = 1'b0;
                                n_led     = 1'b0;
                            end
                        end else begin
                            n_el = el_inc;
                        end
                    end
                end
                lps_pkg::ACT_ON: begin
                    n_running = 1'b0;
                    n_led     = 1'b1;
                end
                lps_pkg::ACT_OFF: begin
                    n_running = 1'b0;
                    n_led     = 1'b0;
                end
                lps_pkg::ACT_TOGGLE: begin
                    n_running = 1'b0;
                    n_led     = ~r_led;
                end
                lps_pkg::ACT_BLINK: begin
                    n_bon     = ta_t;
                    n_boff    = (tb_t != '0) ? tb_t : ta_t;
                    n_running = 1'b1;
                    n_blink   = 1'b1;
                    n_len     = LW'(2);
                    n_step    = '0;
                    n_rep     = 8'd0;
                    n_passes  = 8'd0;
                    n_led     = 1'b1;
                    n_el      = '0;
                end
                lps_pkg::ACT_PLAY: begin
                    // Lengths below two are ignored; odd lengths lose their last entry.
                    if (i_item.pattern_length >= 8'd2) begin
                        n_running = 1'b1;
                        n_blink   = 1'b0;
                        n_len     = len_sat[LW-1:0] & ~LW'(1);
                        n_step    = '0;
                        n_rep     = i_item.repeat_limit;
                        n_passes  = 8'd0;
                        n_led     = 1'b1;
                        n_el      = '0;
                    end
                end
                lps_pkg::ACT_STOP: begin
                    n_running = 1'b0;
                end
                lps_pkg::ACT_WRITE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= ta_t;
        end
        // Write-through so a table write to the next position (n_step) is seen next cycle.
        if (wr_en && (wr_addr == n_step)) begin
            r_rd_data <= ta_t;
        end else begin
            r_rd_data <= mem[n_step];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert  <= 1'b0;
            r_led     <= 1'b0;
            r_running <= 1'b0;
            r_blink   <= 1'b0;
            r_bon     <= '0;
            r_boff    <= '0;
            r_step    <= '0;
            r_len     <= '0;
            r_rep     <= 8'd0;
            r_passes  <= 8'd0;
            r_el      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_invert <= i_cfg_data;
            end
            r_led     <= n_led;
            r_running <= n_running;
            r_blink   <= n_blink;
            r_bon     <= n_bon;
            r_boff    <= n_boff;
            r_step    <= n_step;
            r_len     <= n_len;
            r_rep     <= n_rep;
            r_passes  <= n_passes;
            r_el      <= n_el;
        end
    end

    assign o_result.led_on    = n_led;
    assign o_result.pin_level = n_led ^ r_invert;
    assign o_result.playing   = n_running;

endmodule

`default_nettype wire

>>> hw/rtl/lps_out_q.sv
`timescale 1ns / 1ps
`default_nettype none

module lps_out_q (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  lps_pkg::t_out_item  i_data,
    output logic                o_not_full,
    output logic                o_valid,
    input  wire                 i_ready,
    output lps_pkg::t_out_item  o_data
);

    lps_pkg::t_out_item r_slot [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count, n_count;
    logic               pop;

    assign o_valid    = (r_count != 2'd0);
    assign o_not_full = (r_count != 2'd2);
    assign o_data     = r_slot[r_rd_ptr];
    assign pop        = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lps_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input lps_pkg::t_in_item   i_in_item,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input lps_pkg::t_out_item  o_out_item
);

    // A held result must not change while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Input back-pressure only appears when results are waiting.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // An accepted transaction into an empty queue gives a visible result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> o_out_valid)
        else $error("result missing one cycle after accept");

    // A direct on action lights the LED and ends playback.
    a_on_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid && (i_in_item.action == lps_pkg::ACT_ON)
        |=> o_out_item.led_on && !o_out_item.playing)
        else $error("on action did not light the LED statically");

endmodule

bind led_pattern_sequencer_top lps_checker u_lps_checker (.*);

`default_nettype wire
